### rtl/cng_pkg.sv
// Shared types and constants for the Catalan number generator.
// Holds the field widths, the microcode word layout and the control store.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package cng_pkg;

    localparam int PAIR_COUNT_W = 6;
    localparam int VALUE_W      = 62;
    localparam int ROW_W        = 64;
    localparam int STEP_W       = 3;

    typedef logic [STEP_W-1:0] t_step;

    // Program addresses of the control store.
    localparam t_step STEP_IDLE   = 3'd0;
    localparam t_step STEP_CHECK  = 3'd1;
    localparam t_step STEP_FILL   = 3'd2;
    localparam t_step STEP_PASS   = 3'd3;
    localparam t_step STEP_SWEEP  = 3'd4;
    localparam t_step STEP_DRAIN  = 3'd5;
    localparam t_step STEP_READ0  = 3'd6;
    localparam t_step STEP_RESULT = 3'd7;

    typedef enum logic [1:0] {
        COL_HOLD,
        COL_CLR,
        COL_INC
    } t_col_op;

    typedef enum logic [1:0] {
        PASS_HOLD,
        PASS_CLR,
        PASS_INC
    } t_pass_op;

    // Jump conditions; when the condition is false the program falls through.
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_ITEM,
        COND_OOR,
        COND_FILL_MORE,
        COND_PASSES_DONE,
        COND_SWEEP_MORE,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        logic     take;      // offer ready on the input channel
        t_col_op  col_op;
        t_pass_op pass_op;
        logic     wr_one;    // write 1 to the row at the column counter
        logic     rd_row;    // read the row at column + 1 (sweep)
        logic     rd_zero;   // read entry 0 (answer)
        logic     out_load;  // load the output register when it is free
        t_cond    cond;
        t_step    target;
    } t_uword;

    // Control store: one word per program step.
    function automatic t_uword cng_uop(input t_step step);
        t_uword w;
        w = '{take: 1'b0, col_op: COL_HOLD, pass_op: PASS_HOLD, wr_one: 1'b0,
              rd_row: 1'b0, rd_zero: 1'b0, out_load: 1'b0,
              cond: COND_ALWAYS, target: STEP_IDLE};
        case (step)
            STEP_IDLE: begin
                w.take   = 1'b1;
                w.cond   = COND_NO_ITEM;
                w.target = STEP_IDLE;
            end
            STEP_CHECK: begin
                w.col_op  = COL_CLR;
                w.pass_op = PASS_CLR;
                w.cond    = COND_OOR;
                w.target  = STEP_RESULT;
            end
            STEP_FILL: begin
                w.wr_one = 1'b1;
                w.col_op = COL_INC;
                w.cond   = COND_FILL_MORE;
                w.target = STEP_FILL;
            end
            STEP_PASS: begin
                w.col_op = COL_CLR;
                w.cond   = COND_PASSES_DONE;
                w.target = STEP_READ0;
            end
            STEP_SWEEP: begin
                w.rd_row = 1'b1;
                w.col_op = COL_INC;
                w.cond   = COND_SWEEP_MORE;
                w.target = STEP_SWEEP;
            end
            STEP_DRAIN: begin
                w.pass_op = PASS_INC;
                w.cond    = COND_ALWAYS;
                w.target  = STEP_PASS;
            end
            STEP_READ0: begin
                w.rd_zero = 1'b1;
                w.cond    = COND_ALWAYS;
                w.target  = STEP_RESULT;
            end
            STEP_RESULT: begin
                w.out_load = 1'b1;
                w.cond     = COND_OUT_BUSY;
                w.target   = STEP_RESULT;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/cng_in_if.sv
// Input channel of the Catalan number generator: valid, ready and the count.
// Depends on cng_pkg for the field width.
`default_nettype none

interface cng_in_if;
    logic                              valid;
    logic                              ready;
    logic [cng_pkg::PAIR_COUNT_W-1:0]  pair_count;

    modport source (output valid, output pair_count, input ready);
    modport sink   (input valid, input pair_count, output ready);
endinterface

`default_nettype wire

### rtl/cng_out_if.sv
// Output channel of the Catalan number generator: valid, ready and the result.
// Depends on cng_pkg for the field width.
`default_nettype none

interface cng_out_if;
    logic                          valid;
    logic                          ready;
    logic [cng_pkg::VALUE_W-1:0]   catalan_value;
    logic                          out_of_range;

    modport source (output valid, output catalan_value, output out_of_range, input ready);
    modport sink   (input valid, input catalan_value, input out_of_range, output ready);
endinterface

`default_nettype wire

### rtl/catalan_number_generator_core.sv
// Catalan number generator: a microcoded sequencer over one row memory and one adder.
// A count above MAX_P skips the row work and goes straight to the result.
// One item at a time; the next count is taken as soon as the result sits in the output
// register. The row memory has one write port and one read port; the adder is 64 bits.
// Reset (synchronous, active low) returns the sequencer to idle; the row is not cleared.
`default_nettype none

module catalan_number_generator_core #(
    parameter int MAX_P = 35
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cng_in_if.sink     i_in,
    cng_out_if.source  o_out
);
    import cng_pkg::*;

    // The row holds 2n+1 entries for the largest count that is served.
    localparam int ROW_LEN = 2 * MAX_P + 1;
    localparam int COL_W   = $clog2(ROW_LEN);

    // Sequencer state.
    t_step                    r_step, n_step;
    t_uword                   w_ctl;
    logic                     w_cond_true;

    // Counters and the item being worked on.
    logic [COL_W-1:0]         r_col, n_col;
    logic [PAIR_COUNT_W-1:0]  r_pass, n_pass;
    logic [PAIR_COUNT_W-1:0]  r_n;
    logic [COL_W-1:0]         r_top;
    logic                     r_oor;
    logic [PAIR_COUNT_W:0]    w_top_full;

    // Row memory and the sweep datapath.
    logic [ROW_W-1:0]         r_row [ROW_LEN];
    logic [ROW_W-1:0]         r_rdata;
    logic [ROW_W-1:0]         r_prev;
    logic                     r_pend;
    logic [COL_W-1:0]         r_wcol;
    logic                     w_we;
    logic [COL_W-1:0]         w_waddr;
    logic [ROW_W-1:0]         w_wdata;
    logic                     w_re;
    logic [COL_W-1:0]         w_raddr;
    logic [ROW_W-1:0]         w_sum;

    // Output register.
    logic                     r_out_valid;
    logic [VALUE_W-1:0]       r_out_value;
    logic                     r_out_oor;
    logic                     w_out_free;
    logic                     w_take;

    // ------------------------------------------------------------------
    // Sequencer: fetch the control word of the current step and decide the
    // next step. A true condition jumps to the word's target; otherwise the
    // program falls through to the next step. The result step falls through
    // to the idle step by wrapping the step counter.
    // ------------------------------------------------------------------
    always_comb begin
        w_ctl      = cng_uop(r_step);
        w_out_free = !r_out_valid || o_out.ready;
        w_take     = w_ctl.take && i_in.valid;

        case (w_ctl.cond)
            COND_ALWAYS:      w_cond_true = 1'b1;
            COND_NO_ITEM:     w_cond_true = !i_in.valid;
            COND_OOR:         w_cond_true = r_oor;
            COND_FILL_MORE:   w_cond_true = (r_col != r_top);
            COND_PASSES_DONE: w_cond_true = (r_pass == r_n);
            COND_SWEEP_MORE:  w_cond_true = (r_col != r_top - COL_W'(1));
            COND_OUT_BUSY:    w_cond_true = !w_out_free;
            default:          w_cond_true = 1'b1;
        endcase

        n_step = w_cond_true ? w_ctl.target : r_step + STEP_W'(1);

        case (w_ctl.col_op)
            COL_CLR: n_col = '0;
            COL_INC: n_col = r_col + COL_W'(1);
            default: n_col = r_col;
        endcase

        case (w_ctl.pass_op)
            PASS_CLR: n_pass = '0;
            PASS_INC: n_pass = r_pass + PAIR_COUNT_W'(1);
            default:  n_pass = r_pass;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
            r_col  <= '0;
            r_pass <= '0;
        end else begin
            r_step <= n_step;
            r_col  <= n_col;
            r_pass <= n_pass;
        end
    end

    // ------------------------------------------------------------------
    // Item capture. The top column is 2n; for a refused count its value is
    // never used, so the truncation to the column width is harmless.
    // ------------------------------------------------------------------
    assign w_top_full = {i_in.pair_count, 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_n   <= i_in.pair_count;
            r_top <= w_top_full[COL_W-1:0];
            r_oor <= (i_in.pair_count > PAIR_COUNT_W'(MAX_P));
        end
    end

    assign i_in.ready = w_ctl.take;

    // ------------------------------------------------------------------
    // Sweep datapath. During a pass the sequencer reads old entry m+1 for
    // each column m; in the following cycle the data is back and the new entry m is
    // the new entry m-1 (held in r_prev) plus that old entry, except for
    // column 0, which simply copies old entry 1. Writing column m while
    // reading column m+2 never disturbs a value still to be read. The drain
    // step finishes the last pending write before the next pass starts.
    // The top entry stays 1 from the fill and is never rewritten.
    // ------------------------------------------------------------------
    assign w_sum = ((r_wcol == '0) ? '0 : r_prev) + r_rdata;

    always_comb begin
        w_we    = w_ctl.wr_one || r_pend;
        w_waddr = w_ctl.wr_one ? r_col : r_wcol;
        w_wdata = w_ctl.wr_one ? ROW_W'(1) : w_sum;
        w_re    = w_ctl.rd_row || w_ctl.rd_zero;
        w_raddr = w_ctl.rd_zero ? '0 : r_col + COL_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_row[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_row[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= w_ctl.rd_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.rd_row) begin
            r_wcol <= r_col;
        end
        if (r_pend) begin
            r_prev <= w_sum;
        end
    end

    // ------------------------------------------------------------------
    // Output register. It frees the sequencer to take the next count while
    // the result still waits for its transfer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.out_load && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.out_load && w_out_free) begin
            r_out_value <= r_oor ? '0 : r_rdata[VALUE_W-1:0];
            r_out_oor   <= r_oor;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.catalan_value = r_out_value;
    assign o_out.out_of_range  = r_out_oor;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // An input transfer always starts the program at the range check.
    a_take_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_step == STEP_CHECK))
        else $error("input transfer did not start the range check");

    // A pending sweep write only ever follows a sweep read.
    a_pend_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_step == STEP_SWEEP || r_step == STEP_DRAIN))
        else $error("row write pending outside a pass");

    // The pass counter never runs past the requested count.
    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_PASS || r_step == STEP_SWEEP || r_step == STEP_DRAIN)
        |-> (r_pass < r_n || (r_pass == r_n && r_step == STEP_PASS)))
        else $error("pass counter ran past the count");

    // A refused count always reports a zero value.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.out_of_range) |-> (o_out.catalan_value == '0))
        else $error("out-of-range result carries a nonzero value");

endmodule

`default_nettype wire
